/* rtl/zsp_pkg.sv */
// Package for the zoomed sprite pixel plotter: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package zsp_pkg;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  localparam logic [0:0] CFG_SCROLL_X = 1'b0;
  localparam logic [0:0] CFG_SCROLL_Y = 1'b1;

  localparam logic [9:0] X_BIAS = 10'd386;

  // Operation passed from the front part to the back part.
  typedef struct packed {
    logic        is_byte;
    logic [27:0] fetch_address;
    logic [23:0] fetch_count;
    logic        active;
    logic        last;
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  data;
  } zsp_op_t;

  // Sprite descriptor, held by the front part and read by the back part.
  typedef struct packed {
    logic [9:0]  origin_x;
    logic [8:0]  origin_y;
    logic [11:0] zoom_h;
    logic [11:0] zoom_v;
    logic        mirror_h;
    logic        mirror_v;
    logic [5:0]  palette_bank;
    logic [1:0]  layer_priority;
    logic [11:0] width_pixels;
    logic [11:0] height_pixels;
  } zsp_desc_t;

  // Result item.
  typedef struct packed {
    logic        result_kind;
    logic [27:0] fetch_address;
    logic [23:0] fetch_count;
    logic        write_pixel;
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_word;
    logic        sprite_done;
  } zsp_res_t;

endpackage

/* rtl/zoomed_sprite_pixel_plotter_unit.sv */
// Top level of the zoomed sprite pixel plotter: config registers, front part,
// operation pipeline into the back part. Depends on zsp_pkg, zsp_front, zsp_back.
// An item passes the first back stage and the result register before it shows.
// Throughput: one item per cycle while full is low. An unpopped result moves
// into a skid register; full rises the next cycle, falls the cycle after a pop.
// Reset (rst_n low, synchronous) clears scroll, descriptor, counters and valids.
`timescale 1ns / 1ps
module zoomed_sprite_pixel_plotter_unit import zsp_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [15:0] in_pos_x_word,
  input  logic [15:0] in_pos_y_word,
  input  logic [11:0] in_zoom_x,
  input  logic [11:0] in_zoom_y,
  input  logic [15:0] in_attr_word,
  input  logic [15:0] in_address_low,
  input  logic [15:0] in_size_word,
  input  logic [7:0]  in_gfx_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_result_kind,
  output logic [27:0] out_fetch_address,
  output logic [23:0] out_fetch_count,
  output logic        out_write_pixel,
  output logic [8:0]  out_pixel_x,
  output logic [7:0]  out_pixel_y,
  output logic [15:0] out_pixel_word,
  output logic        out_sprite_done
);

  logic [15:0] scroll_x_r, scroll_y_r;
  logic        go, adv, out_vld, s1_vld, desc_load;
  logic        skid_vld_r, skid_vld_nxt;
  zsp_op_t     op;
  zsp_desc_t   desc;
  zsp_res_t    res, skid_r, out_res;

  // The whole chain moves forward unless the skid register holds an item.
  // When the last stage has a result that is not popped, it is parked in the
  // skid register, so the stall seen by the sender never depends on pop in
  // the same cycle. The descriptor the back part sees in its first stage is
  // captured along with the operation, so a header following a byte is safe.
  assign adv   = !skid_vld_r;
  assign full  = skid_vld_r;
  assign go    = push && !full;
  assign empty = !(skid_vld_r || out_vld);

  // The skid register always holds the older item when both are valid.
  assign out_res = skid_vld_r ? skid_r : res;

  always_comb begin
    if (skid_vld_r) begin
      skid_vld_nxt = !pop;
    end else begin
      skid_vld_nxt = out_vld && !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else begin
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) begin
      skid_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_x_r <= '0;
      scroll_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCROLL_X: scroll_x_r <= cfg_data;
        CFG_SCROLL_Y: scroll_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  zsp_front u_front (
    .clk, .rst_n, .go,
    .kind(in_kind), .pos_x_word(in_pos_x_word), .pos_y_word(in_pos_y_word),
    .zoom_x(in_zoom_x), .zoom_y(in_zoom_y), .attr_word(in_attr_word),
    .address_low(in_address_low), .size_word(in_size_word), .gfx_byte(in_gfx_byte),
    .scroll_x(scroll_x_r), .scroll_y(scroll_y_r),
    .op, .desc, .desc_load
  );

  zsp_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk, .rst_n, .adv, .in_vld(go), .op, .desc, .s1_vld, .out_vld, .res
  );

  assign out_result_kind   = out_res.result_kind;
  assign out_fetch_address = out_res.fetch_address;
  assign out_fetch_count   = out_res.fetch_count;
  assign out_write_pixel   = out_res.write_pixel;
  assign out_pixel_x       = out_res.pixel_x;
  assign out_pixel_y       = out_res.pixel_y;
  assign out_pixel_word    = out_res.pixel_word;
  assign out_sprite_done   = out_res.sprite_done;

  // A header never reports a pixel write.
  a_hdr_nopix: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_result_kind) |-> !out_write_pixel) else $error("header wrote pixel");
  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_res))) else $error("result changed");
  // An accepted item reaches the first back stage.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> s1_vld) else $error("item lost");
  // A header load always comes with acceptance.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    desc_load |-> (push && !full)) else $error("stray load");

endmodule

/* rtl/zsp_front.sv */
// Front part: takes input items, keeps the sprite descriptor and counters, and
// emits one operation per item. Depends on zsp_pkg.
`timescale 1ns / 1ps
module zsp_front import zsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic        kind,
  input  logic [15:0] pos_x_word,
  input  logic [15:0] pos_y_word,
  input  logic [11:0] zoom_x,
  input  logic [11:0] zoom_y,
  input  logic [15:0] attr_word,
  input  logic [15:0] address_low,
  input  logic [15:0] size_word,
  input  logic [7:0]  gfx_byte,
  input  logic [15:0] scroll_x,
  input  logic [15:0] scroll_y,
  output zsp_op_t     op,
  output zsp_desc_t   desc,
  output logic        desc_load
);

  zsp_desc_t   desc_r;
  logic [11:0] col_r, row_r;
  logic        active_r;
  logic [11:0] w, h;
  logic        skip, col_wrap, row_wrap;

  assign w = {size_word[15:8], 4'd0};
  assign h = {size_word[7:0], 4'd0};
  assign skip = (zoom_x == 12'd0) || (zoom_y == 12'd0) || attr_word[15] ||
                (size_word[15:8] == 8'd0) || (size_word[7:0] == 8'd0);
  assign col_wrap = (col_r + 12'd1) >= desc_r.width_pixels;
  assign row_wrap = (row_r + 12'd1) >= desc_r.height_pixels;
  assign desc = desc_r;
  assign desc_load = go && (kind == KIND_HEADER);

  always_comb begin
    op = '0;
    op.is_byte = kind;
    if (kind == KIND_HEADER) begin
      op.fetch_address = {attr_word[3:0], address_low, 8'd0};
      op.fetch_count = skip ? 24'd0 : ({16'd0, size_word[15:8]} * {16'd0, size_word[7:0]}) << 8;
    end else begin
      op.active = active_r;
      op.last = active_r && col_wrap && row_wrap;
      op.col = col_r;
      op.row = row_r;
      op.data = gfx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
      desc_r <= '0;
    end else if (go) begin
      if (kind == KIND_HEADER) begin
        desc_r.origin_x <= pos_x_word[9:0] + X_BIAS - scroll_x[9:0];
        desc_r.origin_y <= pos_y_word[8:0] + 9'd1 - scroll_y[8:0];
        desc_r.zoom_h <= zoom_x;
        desc_r.zoom_v <= zoom_y;
        desc_r.mirror_h <= attr_word[6];
        desc_r.mirror_v <= attr_word[7];
        desc_r.palette_bank <= attr_word[13:8];
        desc_r.layer_priority <= attr_word[5:4];
        desc_r.width_pixels <= w;
        desc_r.height_pixels <= h;
        col_r <= '0;
        row_r <= '0;
        active_r <= !skip;
      end else if (active_r) begin
        if (col_wrap) begin
          col_r <= '0;
          if (row_wrap) begin
            row_r <= '0;
            active_r <= 1'b0;
          end else begin
            row_r <= row_r + 12'd1;
          end
        end else begin
          col_r <= col_r + 12'd1;
        end
      end
    end
  end

endmodule

/* rtl/zsp_back.sv */
// Back part: two-stage pipeline that scales, mirrors and clips one operation
// into a result. Depends on zsp_pkg.
`timescale 1ns / 1ps
module zsp_back import zsp_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_vld,
  input  zsp_op_t   op,
  input  zsp_desc_t desc,
  output logic      s1_vld,
  output logic      out_vld,
  output zsp_res_t  res
);

  logic      s1_vld_r, s2_vld_r;
  zsp_op_t   op1_r;
  zsp_desc_t d1_r;
  logic [23:0] sx_r, ex_r, sy_r, ey_r;
  zsp_res_t  res_r, res_nxt;

  // Zoomed extents reach about 64K pixels, so positions need 18 signed bits.
  logic signed [17:0] bx, by, dx, dy;
  logic onscr;

  assign s1_vld = s1_vld_r;
  assign out_vld = s2_vld_r;
  assign res = res_r;

  always_comb begin
    bx = 18'(signed'(d1_r.origin_x));
    by = 18'(signed'(d1_r.origin_y));
    dx = d1_r.mirror_h ? bx + signed'(18'(ex_r[23:8])) - 18'sd1 - signed'(18'(sx_r[23:8]))
                       : bx + signed'(18'(sx_r[23:8]));
    dy = d1_r.mirror_v ? by + signed'(18'(ey_r[23:8])) - 18'sd1 - signed'(18'(sy_r[23:8]))
                       : by + signed'(18'(sy_r[23:8]));
    onscr = (dx >= 0) && (dx < 18'(SCREEN_WIDTH)) && (dy >= 0) && (dy < 18'(SCREEN_HEIGHT));

    res_nxt = '0;
    res_nxt.result_kind = op1_r.is_byte;
    res_nxt.fetch_address = op1_r.fetch_address;
    res_nxt.fetch_count = op1_r.fetch_count;
    res_nxt.sprite_done = op1_r.last;
    if (op1_r.is_byte && op1_r.active && op1_r.data != 8'd0 && onscr) begin
      res_nxt.write_pixel = 1'b1;
      res_nxt.pixel_x = dx[8:0];
      res_nxt.pixel_y = dy[7:0];
      res_nxt.pixel_word = {d1_r.layer_priority, d1_r.palette_bank, op1_r.data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= op;
      d1_r <= desc;
      sx_r <= {12'd0, op.col} * {12'd0, desc.zoom_h};
      ex_r <= {12'd0, desc.width_pixels} * {12'd0, desc.zoom_h};
      sy_r <= {12'd0, op.row} * {12'd0, desc.zoom_v};
      ey_r <= {12'd0, desc.height_pixels} * {12'd0, desc.zoom_v};
      res_r <= res_nxt;
    end
  end

endmodule
